// ----- rtl/swt_pkg.sv -----
package swt_pkg;

  // Defaults for the top-level parameters
  localparam int TABLE_DEPTH_DEF = 16;
  localparam int WORD_CHARS_DEF  = 8;

  // Fixed field widths
  localparam int CHAR_W      = 8;
  localparam int WORD_W      = 64;
  localparam int INDEX_W     = 4;
  localparam int COUNT_W     = 5;
  localparam int IN_TDATA_W  = 72;   // index(4) + word(64), padded to bytes
  localparam int OUT_TDATA_W = 8;    // found(1) + position(4), padded to bytes

  localparam logic [COUNT_W-1:0] ENTRY_COUNT_RST = 5'd10;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // Relation of table entry to query word, most significant char first
  typedef enum logic [1:0] {
    REL_EQ,
    REL_LT,
    REL_GT
  } rel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CANON,
    ST_WRITE,
    ST_SEARCH,
    ST_LOAD,
    ST_CMP,
    ST_DECIDE,
    ST_DONE
  } state_t;

  // Control for the serial comparator
  typedef struct packed {
    logic en;
    logic start;
  } cmp_ctl_t;

endpackage

// ----- rtl/sorted_word_table_binary_search_top.sv -----
// Channel  Dir  Handshake             Payload
// in       in   in_tvalid/in_tready   tuser: command; tdata: entry_index, word
// out      out  out_tvalid/out_tready tdata: found, position
// cfg      in   cfg_valid/cfg_ready   cfg_data: entry_count
//
// A load canonicalizes the word char by char, then writes it; a search canonicalizes,
//   then runs P probes (up to log2(entry_count)+1), with a final window check on a miss;
//   each probe is a registered table read and a one-char-per-cycle serial compare.
// One beat in flight; the next beat is taken while a result waits in the output register.
// rst_n is synchronous, active low; clears control and entry_count (to 10), not the table.
// A stalled output holds the search engine in DONE until the result register frees.
module sorted_word_table_binary_search_top #(
  parameter int TABLE_DEPTH = swt_pkg::TABLE_DEPTH_DEF,
  parameter int WORD_CHARS  = swt_pkg::WORD_CHARS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic                              in_tuser,   // [0] command
  input  logic [swt_pkg::IN_TDATA_W-1:0]    in_tdata,   // [3:0] entry_index, [67:4] word
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [swt_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [0] found, [4:1] position
  // config write
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [swt_pkg::COUNT_W-1:0]       cfg_data
);

  import swt_pkg::*;

  localparam int W  = CHAR_W * WORD_CHARS;              // significant word bits
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int KW = (WORD_CHARS > 1) ? $clog2(WORD_CHARS) : 1;
  localparam logic [KW-1:0] K_LAST = KW'(WORD_CHARS - 1);
  // Search range never exceeds the depth; count itself tops out at 31.
  localparam logic [COUNT_W-1:0] DEPTH_CAP =
    (TABLE_DEPTH < 31) ? COUNT_W'(TABLE_DEPTH) : COUNT_W'(31);

  state_t               st_r, st_nxt;
  logic [KW-1:0]        k_r, k_nxt;
  logic                 nul_r, nul_nxt;
  logic [W-1:0]         qs_r, qs_nxt;     // query digit shifter
  logic [W-1:0]         q_r, q_nxt;       // canonical query word
  logic [W-1:0]         es_r, es_nxt;     // entry digit shifter
  logic                 cmd_r, cmd_nxt;
  logic [INDEX_W-1:0]   idx_r, idx_nxt;
  logic [COUNT_W-1:0]   lo_r, lo_nxt;     // search window [lo, end)
  logic [COUNT_W-1:0]   end_r, end_nxt;
  logic [COUNT_W-1:0]   mid_r, mid_nxt;
  logic                 found_r, found_nxt;
  logic [INDEX_W-1:0]   pos_r, pos_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [COUNT_W-1:0]   cfg_count_r;

  logic [COUNT_W-1:0]   count_eff;
  logic [COUNT_W-1:0]   mid;
  logic [CHAR_W-1:0]    canon_char;
  logic                 char_nul;
  logic                 idx_ok;

  logic                 wr_en, rd_en;
  logic [W-1:0]         rd_data;
  cmp_ctl_t             cmp_ctl;
  rel_t                 rel;

  assign count_eff = (cfg_count_r > DEPTH_CAP) ? DEPTH_CAP : cfg_count_r;
  assign mid       = lo_r + ((end_r - lo_r - COUNT_W'(1)) >> 1);
  assign char_nul  = (qs_r[W-1 -: CHAR_W] == '0);
  assign canon_char = (nul_r || char_nul) ? '0 : qs_r[W-1 -: CHAR_W];
  assign idx_ok    = (32'(idx_r) < TABLE_DEPTH);

  swt_table #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(idx_r)),
    .wr_data (q_r),
    .rd_en   (rd_en),
    .rd_addr (AW'(mid)),
    .rd_data (rd_data)
  );

  swt_digit_cmp u_cmp (
    .clk     (clk),
    .ctl     (cmp_ctl),
    .digit_a (es_r[W-1 -: CHAR_W]),
    .digit_b (qs_r[W-1 -: CHAR_W]),
    .rel     (rel)
  );

  // Config register; writes must only arrive while idle, which the block itself does not enforce.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r <= ENTRY_COUNT_RST;
    end else if (cfg_valid) begin
      cfg_count_r <= cfg_data;
    end
  end

  always_comb begin
    st_nxt         = st_r;
    k_nxt          = k_r;
    nul_nxt        = nul_r;
    qs_nxt         = qs_r;
    q_nxt          = q_r;
    es_nxt         = es_r;
    cmd_nxt        = cmd_r;
    idx_nxt        = idx_r;
    lo_nxt         = lo_r;
    end_nxt        = end_r;
    mid_nxt        = mid_r;
    found_nxt      = found_r;
    pos_nxt        = pos_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    cmp_ctl.en     = 1'b0;
    cmp_ctl.start  = 1'b0;
    in_tready      = 1'b0;

    unique case (st_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd_nxt   = in_tuser;
          idx_nxt   = in_tdata[INDEX_W-1:0];
          qs_nxt    = in_tdata[INDEX_W+WORD_W-1 -: W];
          nul_nxt   = 1'b0;
          k_nxt     = '0;
          found_nxt = 1'b0;
          pos_nxt   = '0;
          st_nxt    = ST_CANON;
        end
      end

      // Char by char from the top: drop everything after the first NUL.
      ST_CANON: begin
        q_nxt   = (q_r << CHAR_W) | W'(canon_char);
        qs_nxt  = qs_r << CHAR_W;
        nul_nxt = nul_r || char_nul;
        k_nxt   = k_r + KW'(1);
        if (k_r == K_LAST) begin
          k_nxt = '0;
          if (cmd_r == CMD_LOAD) begin
            st_nxt = ST_WRITE;
          end else begin
            lo_nxt  = '0;
            end_nxt = count_eff;
            st_nxt  = ST_SEARCH;
          end
        end
      end

      ST_WRITE: begin
        wr_en  = idx_ok;
        st_nxt = ST_DONE;
      end

      ST_SEARCH: begin
        if (lo_r < end_r) begin
          rd_en   = 1'b1;
          mid_nxt = mid;
          qs_nxt  = q_r;
          st_nxt  = ST_LOAD;
        end else begin
          st_nxt = ST_DONE;
        end
      end

      ST_LOAD: begin
        es_nxt = rd_data;
        k_nxt  = '0;
        st_nxt = ST_CMP;
      end

      ST_CMP: begin
        cmp_ctl.en    = 1'b1;
        cmp_ctl.start = (k_r == '0);
        es_nxt        = es_r << CHAR_W;
        qs_nxt        = qs_r << CHAR_W;
        k_nxt         = k_r + KW'(1);
        if (k_r == K_LAST) begin
          k_nxt  = '0;
          st_nxt = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        unique case (rel)
          REL_EQ: begin
            found_nxt = 1'b1;
            pos_nxt   = mid_r[INDEX_W-1:0];
            st_nxt    = ST_DONE;
          end
          REL_LT: begin
            lo_nxt = mid_r + COUNT_W'(1);
            st_nxt = ST_SEARCH;
          end
          default: begin
            end_nxt = mid_r;
            st_nxt  = ST_SEARCH;
          end
        endcase
      end

      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = OUT_TDATA_W'({pos_r, found_r});
          st_nxt         = ST_IDLE;
        end
      end

      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r         <= k_nxt;
    nul_r       <= nul_nxt;
    qs_r        <= qs_nxt;
    q_r         <= q_nxt;
    es_r        <= es_nxt;
    cmd_r       <= cmd_nxt;
    idx_r       <= idx_nxt;
    lo_r        <= lo_nxt;
    end_r       <= end_nxt;
    mid_r       <= mid_nxt;
    found_r     <= found_nxt;
    pos_r       <= pos_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTHESIS
  // a probe always lies inside the current window
  a_mid_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_LOAD) |-> (mid_r >= lo_r) && (mid_r < end_r))
    else $error("probe outside search window");

  // window never grows past the clamped count
  a_window_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SEARCH) |-> (lo_r <= end_r) && (end_r <= DEPTH_CAP))
    else $error("search window out of range");

  // a load never reports a hit
  a_load_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DONE && cmd_r == CMD_LOAD) |-> !found_r && (pos_r == '0))
    else $error("load produced a hit");

  // a fresh result only follows the DONE state
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !$past(out_tvalid_r)) |-> ($past(st_r) == ST_DONE))
    else $error("result issued outside DONE");
`endif

endmodule

// ----- rtl/swt_table.sv -----
module swt_table #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/swt_digit_cmp.sv -----
module swt_digit_cmp (
  input  logic                         clk,
  input  swt_pkg::cmp_ctl_t            ctl,
  input  logic [swt_pkg::CHAR_W-1:0]   digit_a,
  input  logic [swt_pkg::CHAR_W-1:0]   digit_b,
  output swt_pkg::rel_t                rel
);

  import swt_pkg::*;

  rel_t rel_r, rel_nxt, digit_rel;

  // First differing char (MSB first) decides; later chars are ignored.
  always_comb begin
    if (digit_a < digit_b) begin
      digit_rel = REL_LT;
    end else if (digit_a > digit_b) begin
      digit_rel = REL_GT;
    end else begin
      digit_rel = REL_EQ;
    end

    rel_nxt = rel_r;
    if (ctl.en) begin
      if (ctl.start || (rel_r == REL_EQ)) begin
        rel_nxt = digit_rel;
      end
    end
  end

  always_ff @(posedge clk) begin
    rel_r <= rel_nxt;
  end

  assign rel = rel_r;

endmodule

// ----- bench/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import swt_pkg::*;

  // Longest stretch with no beat on any channel before the run is declared hung.
  // The worst honest stretch is the long output hold-off plus one full search
  // plus the largest idle gaps, so this leaves ample room.
  localparam int STUCK_LIMIT = 4000;
  localparam int HOLD_OFF    = 300;
  localparam int TAIL_CYCLES = 100;

  typedef struct packed {
    logic       found;
    logic [3:0] position;
  } lookup_result_t;

  // One directed stimulus row; typed rows carry their own expected result.
  typedef struct {
    logic           cmd;
    logic [3:0]     idx;
    logic [63:0]    word;
    bit             typed;
    lookup_result_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic                   in_tuser = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;    // [3:0] entry_index, [67:4] word, [71:68] zero
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // [0] found, [4:1] position
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [COUNT_W-1:0]     cfg_data = '0;

  // Shadow of the block: canonical table contents and the entry count in use.
  logic [WORD_W-1:0]  table_shadow [TABLE_DEPTH_DEF];
  logic [COUNT_W-1:0] entries_in_use;

  lookup_result_t pending_lookups [$];
  dir_row_t       directed_rows [$];

  int mismatches   = 0;
  int stuck_cycles = 0;
  int hold_request = 0;   // receiver picks this up as one long stall
  int calm_left    = 0;   // sender beats left with no idle gap

  sorted_word_table_binary_search_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // A word ends at its first NUL; bytes past WORD_CHARS are dropped too.
  function automatic logic [WORD_W-1:0] canon_word(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] keep;
    logic [WORD_W-1:0] res;
    bit                ended;
    int                b;
    keep  = ~64'd0 << (WORD_W - CHAR_W * WORD_CHARS_DEF);
    w     = w & keep;
    res   = '0;
    ended = 1'b0;
    for (b = 7; b >= 0; b--) begin
      if (w[b*8 +: 8] == 8'h00) ended = 1'b1;
      if (!ended) res[b*8 +: 8] = w[b*8 +: 8];
    end
    return res;
  endfunction

  // Number of leading non-NUL characters.
  function automatic int word_chars(input logic [WORD_W-1:0] w);
    int n;
    n = 0;
    while (n < 8 && w[(7-n)*8 +: 8] != 8'h00) n++;
    return n;
  endfunction

  // Random garbage below the terminating NUL; canonical value is unchanged.
  function automatic logic [WORD_W-1:0] add_junk(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] res;
    int                len;
    int                b;
    res = canon_word(w);
    len = word_chars(res);
    for (b = 0; b <= 6 - len; b++) res[b*8 +: 8] = 8'($urandom_range(0, 255));
    return res;
  endfunction

  // Narrow alphabet gives shared prefixes and duplicates.
  function automatic logic [WORD_W-1:0] rand_word(input bit narrow);
    logic [WORD_W-1:0] w;
    int                len;
    int                i;
    w   = '0;
    len = $urandom_range(0, 8);
    for (i = 0; i < len; i++)
      w[(7-i)*8 +: 8] = narrow ? 8'($urandom_range(97, 100)) : 8'($urandom_range(1, 255));
    if ($urandom_range(0, 1) == 1) w = add_junk(w);
    return w;
  endfunction

  // Applies one beat to the shadow and returns the result it should produce.
  function automatic lookup_result_t predict_lookup(input logic cmd, input logic [3:0] idx,
                                                    input logic [WORD_W-1:0] w);
    lookup_result_t    r;
    logic [WORD_W-1:0] key;
    int                span;
    int                lo;
    int                hi;
    int                mid;
    r   = '0;
    key = canon_word(w);
    if (cmd == CMD_LOAD) begin
      if (int'(idx) < TABLE_DEPTH_DEF) table_shadow[idx] = key;
    end else begin
      span = (int'(entries_in_use) > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(entries_in_use);
      lo   = 0;
      hi   = span - 1;
      while (lo <= hi && !r.found) begin
        mid = lo + (hi - lo) / 2;
        if (table_shadow[mid] == key) begin
          r.found    = 1'b1;
          r.position = mid[3:0];
        end else if (table_shadow[mid] < key) begin
          lo = mid + 1;
        end else begin
          hi = mid - 1;
        end
      end
    end
    return r;
  endfunction

  function automatic void add_row(input logic cmd, input logic [3:0] idx,
                                  input logic [WORD_W-1:0] w, input bit typed,
                                  input logic f, input logic [3:0] pos);
    dir_row_t row;
    row.cmd          = cmd;
    row.idx          = idx;
    row.word         = w;
    row.typed        = typed;
    row.res.found    = f;
    row.res.position = pos;
    directed_rows.push_back(row);
  endfunction

  // Offers one input beat after a random gap and records its expected result
  // once it is taken. tvalid is left high so a back-to-back beat needs no dip.
  task automatic offer_item(input logic cmd, input logic [3:0] idx,
                            input logic [WORD_W-1:0] w, input bit typed,
                            input lookup_result_t typed_res);
    int             gap;
    lookup_result_t want;
    if (calm_left > 0) begin
      gap = 0;
      calm_left--;
    end else begin
      gap = $urandom_range(0, 12);
      if ($urandom_range(0, 14) == 0) calm_left = $urandom_range(5, 30);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'b0000, w, idx};
    do @(posedge clk); while (in_tready !== 1'b1);
    want = predict_lookup(cmd, idx, w);
    if (typed) want = typed_res;
    pending_lookups.push_back(want);
  endtask

  // Drop tvalid and wait for every outstanding result.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
  endtask

  // entry_count is only rewritten with the block empty.
  task automatic set_entry_count(input logic [COUNT_W-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    entries_in_use = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hang detector: cycles with no beat on any of the three channels.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, stuck_cycles);
      $display("sorted_word_table_binary_search_top regression: fail");
      $finish;
    end
  end

  // Result sink: random stall per beat, calm stretches, and one long hold-off
  // on request so the block backs up into its input.
  initial begin : result_sink
    int             stall;
    int             calm;
    lookup_result_t want;
    lookup_result_t got;
    calm = 0;
    forever begin
      if (hold_request > 0) begin
        stall        = hold_request;
        hold_request = 0;
      end else if (calm > 0) begin
        stall = 0;
        calm--;
      end else begin
        stall = $urandom_range(0, 12);
        if ($urandom_range(0, 19) == 0) calm = $urandom_range(5, 30);
      end
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      got.found    = out_tdata[0];
      got.position = out_tdata[4:1];
      if (pending_lookups.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual found=%0d position=%0d",
                 $time, got.found, got.position);
        mismatches++;
      end else begin
        want = pending_lookups.pop_front();
        if (got.found !== want.found) begin
          $display("%0t: found mismatch: expected %0d, actual %0d",
                   $time, want.found, got.found);
          mismatches++;
        end
        if (got.position !== want.position) begin
          $display("%0t: position mismatch: expected %0d, actual %0d",
                   $time, want.position, got.position);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    dir_row_t          row;
    lookup_result_t    no_res;
    logic [WORD_W-1:0] raw [TABLE_DEPTH_DEF];
    logic [WORD_W-1:0] tmp;
    logic [WORD_W-1:0] w;
    logic [3:0]        slot;
    logic [3:0]        idx;
    logic [COUNT_W-1:0] count;
    bit                narrow;
    bit                moving;
    int                p;
    int                i;
    int                j;
    int                span;
    int                pick;
    int                len;

    no_res = '0;
    for (i = 0; i < TABLE_DEPTH_DEF; i++) table_shadow[i] = '0;
    entries_in_use = ENTRY_COUNT_RST;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- Directed part, entry_count at its reset value of 10 ----
    // Fill every entry with a sorted set first: no search may touch an
    // entry that was never written. Load results are always found 0, pos 0.
    add_row(CMD_LOAD, 4'd0,  64'h0000_0000_0000_0000, 1'b1, 1'b0, 4'd0);  // empty word
    add_row(CMD_LOAD, 4'd1,  64'h6100_0000_0000_0000, 1'b1, 1'b0, 4'd0);  // "a"
    add_row(CMD_LOAD, 4'd2,  64'h6162_00FF_1234_5678, 1'b1, 1'b0, 4'd0);  // "ab" + junk
    add_row(CMD_LOAD, 4'd3,  64'h6162_6300_0000_0000, 1'b1, 1'b0, 4'd0);  // "abc"
    add_row(CMD_LOAD, 4'd4,  64'h6200_0000_0000_0000, 1'b1, 1'b0, 4'd0);  // "b"
    add_row(CMD_LOAD, 4'd5,  64'h6361_7400_0000_0000, 1'b1, 1'b0, 4'd0);  // "cat"
    add_row(CMD_LOAD, 4'd6,  64'h646F_6700_0000_0000, 1'b1, 1'b0, 4'd0);  // "dog"
    add_row(CMD_LOAD, 4'd7,  64'h6865_6C6C_6F00_0000, 1'b1, 1'b0, 4'd0);  // "hello"
    add_row(CMD_LOAD, 4'd8,  64'h7A65_6272_6100_0000, 1'b1, 1'b0, 4'd0);  // "zebra"
    add_row(CMD_LOAD, 4'd9,  64'h7A7A_0000_0000_0000, 1'b1, 1'b0, 4'd0);  // "zz"
    add_row(CMD_LOAD, 4'd10, 64'h7A7A_7A7A_7A7A_7A7A, 1'b1, 1'b0, 4'd0);  // eight chars
    add_row(CMD_LOAD, 4'd11, 64'h8000_0000_0000_0000, 1'b1, 1'b0, 4'd0);
    add_row(CMD_LOAD, 4'd12, 64'hC0FF_EE00_0000_0000, 1'b1, 1'b0, 4'd0);
    add_row(CMD_LOAD, 4'd13, 64'hFE00_0000_0000_0000, 1'b1, 1'b0, 4'd0);
    add_row(CMD_LOAD, 4'd14, 64'hFFFF_FFFF_FFFF_FF00, 1'b1, 1'b0, 4'd0);
    add_row(CMD_LOAD, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 4'd0);  // all ones
    // Searches; the index field is junk here and must be ignored.
    add_row(CMD_SEARCH, 4'hF, 64'h6865_6C6C_6F00_0000, 1'b0, 1'b0, 4'd0);  // hit mid table
    add_row(CMD_SEARCH, 4'h5, 64'h0000_0000_0000_0000, 1'b0, 1'b0, 4'd0);  // empty word
    add_row(CMD_SEARCH, 4'hA, 64'h6162_0055_AA00_0001, 1'b0, 1'b0, 4'd0);  // junk after NUL
    add_row(CMD_SEARCH, 4'h0, 64'h6162_6300_0000_0000, 1'b0, 1'b0, 4'd0);  // same first char
    add_row(CMD_SEARCH, 4'h3, 64'h7A7A_0000_0000_0000, 1'b0, 1'b0, 4'd0);  // last in use
    add_row(CMD_SEARCH, 4'h9, 64'h7A7A_7A7A_7A7A_7A7A, 1'b0, 1'b0, 4'd0);  // past count
    add_row(CMD_SEARCH, 4'h7, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 4'd0);  // all ones
    add_row(CMD_SEARCH, 4'hC, 64'h6361_0000_0000_0000, 1'b0, 1'b0, 4'd0);  // between entries
    add_row(CMD_SEARCH, 4'h1, 64'h6162_6400_0000_0000, 1'b0, 1'b0, 4'd0);  // near miss

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      offer_item(row.cmd, row.idx, row.word, row.typed, row.res);
    end

    // ---- Random phases, each under its own entry_count ----
    // Each phase reloads a fresh sorted table and then mixes mostly hits and
    // near misses with random searches and a few loads that break the order.
    for (p = 0; p < 8; p++) begin
      case (p)
        0:       count = 5'd16;
        1:       count = 5'd1;
        2:       count = 5'd0;
        3:       count = 5'd31;
        4:       count = 5'($urandom_range(2, 15));
        5:       count = 5'($urandom_range(17, 30));
        6:       count = 5'($urandom_range(1, 16));
        default: count = 5'($urandom_range(2, 15));
      endcase
      set_entry_count(count);
      narrow = 1'($urandom_range(0, 1));

      // Back-pressure: the sink holds off for a long stretch while the
      // source keeps offering back-to-back beats, so the input stalls.
      if (p == 2 || p == 5) begin
        hold_request = HOLD_OFF;
        calm_left    = 30;
      end

      for (i = 0; i < TABLE_DEPTH_DEF; i++) begin
        raw[i] = rand_word(narrow);
        if (i > 0 && $urandom_range(0, 9) == 0) raw[i] = add_junk(raw[i-1]);  // duplicate
      end
      for (i = 1; i < TABLE_DEPTH_DEF; i++) begin
        tmp    = raw[i];
        j      = i;
        moving = 1'b1;
        while (j > 0 && moving) begin
          if (canon_word(raw[j-1]) > canon_word(tmp)) begin
            raw[j] = raw[j-1];
            j--;
          end else begin
            moving = 1'b0;
          end
        end
        raw[j] = tmp;
      end
      for (i = 0; i < TABLE_DEPTH_DEF; i++) begin
        slot = 4'(i);
        offer_item(CMD_LOAD, slot, raw[i], 1'b0, no_res);
      end

      repeat (74) begin
        span = (int'(entries_in_use) > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF
                                                         : int'(entries_in_use);
        pick = $urandom_range(0, 99);
        idx  = 4'($urandom_range(0, 15));
        if (pick < 55) begin
          // likely hit, sometimes with garbage after the NUL
          slot = (span == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, span - 1));
          w    = table_shadow[slot];
          if ($urandom_range(0, 2) == 0) w = add_junk(w);
          offer_item(CMD_SEARCH, idx, w, 1'b0, no_res);
        end else if (pick < 72) begin
          // near miss: one more char, or the last char nudged by one
          slot = 4'($urandom_range(0, 15));
          w    = table_shadow[slot];
          len  = word_chars(w);
          if (len < 8 && $urandom_range(0, 1) == 1)
            w[(7-len)*8 +: 8] = 8'($urandom_range(1, 255));
          else if (len > 0)
            w[(8-len)*8 +: 8] = w[(8-len)*8 +: 8] + (($urandom_range(0, 1) == 1) ? 8'h01 : 8'hFF);
          offer_item(CMD_SEARCH, idx, w, 1'b0, no_res);
        end else if (pick < 82) begin
          offer_item(CMD_SEARCH, idx, {$urandom, $urandom}, 1'b0, no_res);
        end else if (pick < 90) begin
          // noise load: table may become unsorted or hold duplicates
          w = ($urandom_range(0, 1) == 1) ? rand_word(narrow) : {$urandom, $urandom};
          offer_item(CMD_LOAD, idx, w, 1'b0, no_res);
        end else begin
          // rewrite an entry with the same word and fresh junk
          offer_item(CMD_LOAD, idx, add_junk(table_shadow[idx]), 1'b0, no_res);
        end
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("sorted_word_table_binary_search_top regression: pass");
    else
      $display("sorted_word_table_binary_search_top regression: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/swt_pkg.sv
rtl/swt_table.sv
rtl/swt_digit_cmp.sv
rtl/sorted_word_table_binary_search_top.sv
bench/tb.sv
